>>> hw/rtl/ppm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, limits, register indexes and types of the periodic pattern
// phase finder.
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int BASE_W       = 8;
   localparam int QUAL_W       = 8;
   localparam int CHAR_W       = 8;
   localparam int NUM_CHARS    = 8;
   localparam int LEN_CFG_W    = 4;
   localparam int CHARS_W      = NUM_CHARS * CHAR_W;
   localparam int COUNT_W      = 9;
   localparam int QSUM_W       = 16;
   localparam int WORD_W       = 64;
   localparam int WORD_BITS_W  = 6;
   localparam int OFFSET_OUT_W = 3;
   localparam int WIDX_W       = 2;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 64;

   localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
   localparam logic [QSUM_W-1:0]    QSUM_MAX      = '1;
   localparam logic [LEN_CFG_W-1:0] PAT_LEN_RESET = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS  = 4'd1;

   // end-of-read handoff from the accumulator to the emitter
   typedef struct packed {
      logic valid;
      logic bank;
      logic overflow;
   } ppm_done_type;

   typedef struct packed {
      logic [OFFSET_OUT_W-1:0] best_offset;
      logic [COUNT_W-1:0]      mismatch_count;
      logic [WORD_W-1:0]       bitmap_word;
      logic [WIDX_W-1:0]       word_index;
      logic                    overflow;
      logic                    last_word;
   } ppm_rsp_type;

endpackage

>>> hw/rtl/periodic_pattern_phase_mismatch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_pattern_phase_mismatch_top
// Compares a streamed read against a repeating pattern at every phase offset
// and returns the mismatch bitmap of the best offset in 64-bit words.
// ----------------------------------------------------------------------------
// Throughput: one base per cycle; a last base waits while the previous read's
//   bitmap rows (ceil(len/64) words) are still being read from the RAM.
// Output: the offset select and a RAM read follow the last base; then one
//   word per cycle while rsp_ready is high, set by the single RAM read port.
// Reset: synchronous, clears counters and queue; registers return to pattern
//   length 6 and zero pattern characters. Bitmap RAM needs no clearing.
// ----------------------------------------------------------------------------
module periodic_pattern_phase_mismatch_top #(
   parameter int MAX_READ_LEN    = 256,
   parameter int MAX_PATTERN_LEN = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ppm_pkg::BASE_W-1:0]         req_base,
   input  logic [ppm_pkg::QUAL_W-1:0]         req_quality,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ppm_pkg::OFFSET_OUT_W-1:0]   rsp_best_offset,
   output logic [ppm_pkg::COUNT_W-1:0]        rsp_mismatch_count,
   output logic [ppm_pkg::WORD_W-1:0]         rsp_bitmap_word,
   output logic [ppm_pkg::WIDX_W-1:0]         rsp_word_index,
   output logic                               rsp_overflow,
   output logic                               rsp_last_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ppm_pkg::*;

   localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
   localparam int ROWS   = (MAX_READ_LEN + WORD_W - 1) / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = ROW_W + 1;
   localparam int DATA_W = MAX_PATTERN_LEN * WORD_W;
   localparam int DEPTH  = 2 * (1 << ROW_W);

   logic [LEN_CFG_W-1:0]              pattern_length_ff;
   logic [CHARS_W-1:0]                pattern_chars_ff;
   logic                              emit_busy;
   logic                              wr_en;
   logic [ADDR_W-1:0]                 wr_addr;
   logic [DATA_W-1:0]                 wr_data;
   logic                              rd_en;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [DATA_W-1:0]                 rd_data;
   ppm_done_type                      done;
   logic [LEN_W-1:0]                  done_len;
   logic [MAX_PATTERN_LEN-1:0][COUNT_W-1:0] done_counts;
   logic [MAX_PATTERN_LEN-1:0][QSUM_W-1:0]  done_qsums;
   logic [ROW_W-1:0]                  done_last_row;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= PAT_LEN_RESET;
         pattern_chars_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_CFG_W-1:0];
            CSR_PATTERN_CHARS:  pattern_chars_ff  <= csr_data[CHARS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ppm_accum #(
      .MAX_READ_LEN    (MAX_READ_LEN),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_base       (req_base),
      .req_quality    (req_quality),
      .req_last       (req_last),
      .pattern_length (pattern_length_ff),
      .pattern_chars  (pattern_chars_ff),
      .emit_busy      (emit_busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .done           (done),
      .done_len       (done_len),
      .done_counts    (done_counts),
      .done_qsums     (done_qsums),
      .done_last_row  (done_last_row)
   );

   ppm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ppm_emit #(
      .MAX_READ_LEN    (MAX_READ_LEN),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_emit (
      .clock              (clock),
      .reset              (reset),
      .done               (done),
      .done_len           (done_len),
      .done_counts        (done_counts),
      .done_qsums         (done_qsums),
      .done_last_row      (done_last_row),
      .emit_busy          (emit_busy),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_best_offset    (rsp_best_offset),
      .rsp_mismatch_count (rsp_mismatch_count),
      .rsp_bitmap_word    (rsp_bitmap_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_word      (rsp_last_word)
   );

   // a read may only close once the emitter has released its bank
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |-> !emit_busy)
      else $error("last base accepted while emitter busy");

   // writer and reader always sit in different banks
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("row RAM read and write collide");

   assert property (@(posedge clock) disable iff (reset)
      $rose(emit_busy) |-> $past(req_valid && req_ready && req_last))
      else $error("emitter started without a closed read");

endmodule

>>> hw/rtl/ppm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ppm_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_accum
// Per-base compare at every phase offset, mismatch count and quality sum
// accumulation, and assembly of mismatch bitmap rows written to the RAM.
// ----------------------------------------------------------------------------
module ppm_accum #(
   parameter int MAX_READ_LEN    = 256,
   parameter int MAX_PATTERN_LEN = 8,
   localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1),
   localparam int ROWS   = (MAX_READ_LEN + ppm_pkg::WORD_W - 1) / ppm_pkg::WORD_W,
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ADDR_W = ROW_W + 1,
   localparam int DATA_W = MAX_PATTERN_LEN * ppm_pkg::WORD_W
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 req_valid,
   output logic                                                 req_ready,
   input  logic [ppm_pkg::BASE_W-1:0]                           req_base,
   input  logic [ppm_pkg::QUAL_W-1:0]                           req_quality,
   input  logic                                                 req_last,
   input  logic [ppm_pkg::LEN_CFG_W-1:0]                        pattern_length,
   input  logic [ppm_pkg::CHARS_W-1:0]                          pattern_chars,
   input  logic                                                 emit_busy,
   output logic                                                 wr_en,
   output logic [ADDR_W-1:0]                                    wr_addr,
   output logic [DATA_W-1:0]                                    wr_data,
   output ppm_pkg::ppm_done_type                                done,
   output logic [LEN_W-1:0]                                     done_len,
   output logic [MAX_PATTERN_LEN-1:0][ppm_pkg::COUNT_W-1:0]     done_counts,
   output logic [MAX_PATTERN_LEN-1:0][ppm_pkg::QSUM_W-1:0]      done_qsums,
   output logic [ROW_W-1:0]                                     done_last_row
);
   import ppm_pkg::*;

   localparam int MPL   = MAX_PATTERN_LEN;
   localparam int OFS_W = (MPL > 1) ? $clog2(MPL) : 1;
   localparam int SUM_W = OFS_W + 1;
   localparam int POS_W = $clog2(MAX_READ_LEN + 1);

   logic                              accept;
   logic                              rec;
   logic                              rec_acc;
   logic [LEN_W-1:0]                  len;
   logic [OFS_W-1:0]                  phase0;
   logic [MPL-1:0]                    mm;
   logic [MPL-1:0][OFS_W-1:0]         rem_ff, rem_in;
   logic [MPL-1:0][COUNT_W-1:0]       cnt_ff, cnt_in;
   logic [MPL-1:0][QSUM_W-1:0]        qs_ff, qs_in;
   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic                              ovf_ff;
   logic                              bank_ff;
   logic [DATA_W-1:0]                 row_ff, row_in;

   assign req_ready = !(emit_busy && req_last);
   assign accept    = req_valid && req_ready;
   assign rec       = pos_ff < POS_W'(MAX_READ_LEN);
   assign rec_acc   = accept && rec;

   always_comb begin
      if (pattern_length == '0) begin
         len = LEN_W'(1);
      end else if ({1'b0, pattern_length} > (LEN_CFG_W + 1)'(MPL)) begin
         len = LEN_W'(MPL);
      end else begin
         len = LEN_W'(pattern_length);
      end
   end

   assign phase0 = rem_ff[OFS_W'(len - LEN_W'(1))];

   // pattern character index at offset o is (o + phase0) mod len
   always_comb begin
      logic [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]  k;
      logic [CHAR_W-1:0] chr;
      for (int o = 0; o < MPL; o++) begin
         sum = SUM_W'(o) + SUM_W'(phase0);
         k   = (sum >= SUM_W'(len)) ? sum - SUM_W'(len) : sum;
         chr = '0;
         for (int c = 0; c < NUM_CHARS; c++) begin
            if (c < (1 << SUM_W) && k == SUM_W'(c)) begin
               chr = pattern_chars[c*CHAR_W +: CHAR_W];
            end
         end
         mm[o] = (LEN_W'(o) < len) && (req_base != chr);
      end
   end

   always_comb begin
      logic [QSUM_W:0] qsum;
      for (int o = 0; o < MPL; o++) begin
         cnt_in[o] = cnt_ff[o];
         qs_in[o]  = qs_ff[o];
         qsum      = {1'b0, qs_ff[o]} + (QSUM_W + 1)'(req_quality);
         if (rec_acc && mm[o]) begin
            if (cnt_ff[o] != COUNT_MAX) begin
               cnt_in[o] = cnt_ff[o] + COUNT_W'(1);
            end
            qs_in[o] = qsum[QSUM_W] ? QSUM_MAX : qsum[QSUM_W-1:0];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < MPL; j++) begin
         if (!rec) begin
            rem_in[j] = rem_ff[j];
         end else if (rem_ff[j] == OFS_W'(j)) begin
            rem_in[j] = '0;
         end else begin
            rem_in[j] = rem_ff[j] + OFS_W'(1);
         end
      end
   end

   assign pos_in = rec ? pos_ff + POS_W'(1) : pos_ff;

   always_comb begin
      row_in = (pos_ff[WORD_BITS_W-1:0] == '0) ? '0 : row_ff;
      for (int o = 0; o < MPL; o++) begin
         row_in[o*WORD_W + int'(pos_ff[WORD_BITS_W-1:0])] = mm[o];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
         bank_ff <= 1'b0;
         cnt_ff  <= '0;
         qs_ff   <= '0;
         rem_ff  <= '0;
      end else if (accept) begin
         if (req_last) begin
            pos_ff  <= '0;
            ovf_ff  <= 1'b0;
            bank_ff <= !bank_ff;
            cnt_ff  <= '0;
            qs_ff   <= '0;
            rem_ff  <= '0;
         end else begin
            pos_ff <= pos_in;
            ovf_ff <= ovf_ff || !rec;
            cnt_ff <= cnt_in;
            qs_ff  <= qs_in;
            rem_ff <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_acc) begin
         row_ff <= row_in;
      end
   end

   assign wr_en   = rec_acc;
   assign wr_addr = {bank_ff, ROW_W'(pos_ff >> WORD_BITS_W)};
   assign wr_data = row_in;

   assign done.valid    = accept && req_last;
   assign done.bank     = bank_ff;
   assign done.overflow = ovf_ff || !rec;
   assign done_len      = len;
   assign done_counts   = cnt_in;
   assign done_qsums    = qs_in;
   assign done_last_row = (pos_in == '0) ? '0
                          : ROW_W'((pos_in - POS_W'(1)) >> WORD_BITS_W);

endmodule

>>> hw/rtl/ppm_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_emit
// Best offset selection at end of read, bitmap row read-out from the RAM and
// a two-word output queue toward the result channel.
// ----------------------------------------------------------------------------
module ppm_emit #(
   parameter int MAX_READ_LEN    = 256,
   parameter int MAX_PATTERN_LEN = 8,
   localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1),
   localparam int ROWS   = (MAX_READ_LEN + ppm_pkg::WORD_W - 1) / ppm_pkg::WORD_W,
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int ADDR_W = ROW_W + 1,
   localparam int DATA_W = MAX_PATTERN_LEN * ppm_pkg::WORD_W
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  ppm_pkg::ppm_done_type                             done,
   input  logic [LEN_W-1:0]                                  done_len,
   input  logic [MAX_PATTERN_LEN-1:0][ppm_pkg::COUNT_W-1:0]  done_counts,
   input  logic [MAX_PATTERN_LEN-1:0][ppm_pkg::QSUM_W-1:0]   done_qsums,
   input  logic [ROW_W-1:0]                                  done_last_row,
   output logic                                              emit_busy,
   output logic                                              rd_en,
   output logic [ADDR_W-1:0]                                 rd_addr,
   input  logic [DATA_W-1:0]                                 rd_data,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic [ppm_pkg::OFFSET_OUT_W-1:0]                  rsp_best_offset,
   output logic [ppm_pkg::COUNT_W-1:0]                       rsp_mismatch_count,
   output logic [ppm_pkg::WORD_W-1:0]                        rsp_bitmap_word,
   output logic [ppm_pkg::WIDX_W-1:0]                        rsp_word_index,
   output logic                                              rsp_overflow,
   output logic                                              rsp_last_word
);
   import ppm_pkg::*;

   localparam int MPL   = MAX_PATTERN_LEN;
   localparam int OFS_W = (MPL > 1) ? $clog2(MPL) : 1;

   typedef enum logic [2:0] {
      EMIT_IDLE   = 3'b001,
      EMIT_SELECT = 3'b010,
      EMIT_ISSUE  = 3'b100
   } emit_state_type;

   emit_state_type              state_ff, state_in;
   logic [MPL-1:0][COUNT_W-1:0] cnt_s_ff;
   logic [MPL-1:0][QSUM_W-1:0]  qs_s_ff;
   logic [LEN_W-1:0]            len_s_ff;
   logic                        bank_s_ff;
   logic                        ovf_s_ff;
   logic [ROW_W-1:0]            lastw_s_ff;
   logic [OFS_W-1:0]            best_sel;
   logic [OFS_W-1:0]            best_ff;
   logic [COUNT_W-1:0]          bcnt_ff;
   logic [ROW_W-1:0]            w_ff;
   logic                        issue;
   logic                        issue_last;
   logic                        inflight_ff;
   logic [ROW_W-1:0]            inf_w_ff;
   logic                        inf_last_ff;
   logic [1:0]                  occ_ff;
   logic [2:0]                  used;
   logic                        push;
   logic                        pop;
   logic                        slot;
   ppm_rsp_type                 entry;
   ppm_rsp_type                 q_ff [2];

   // lowest count, then lowest quality sum, then lowest offset
   always_comb begin
      logic [OFS_W-1:0] b;
      b = '0;
      for (int o = 1; o < MPL; o++) begin
         if (LEN_W'(o) < len_s_ff &&
             (cnt_s_ff[o] < cnt_s_ff[b] ||
              (cnt_s_ff[o] == cnt_s_ff[b] && qs_s_ff[o] < qs_s_ff[b]))) begin
            b = OFS_W'(o);
         end
      end
      best_sel = b;
   end

   assign pop        = rsp_valid && rsp_ready;
   assign push       = inflight_ff;
   assign used       = 3'(occ_ff) + 3'(inflight_ff) - 3'(pop);
   assign issue      = (state_ff == EMIT_ISSUE) && (used < 3'd2);
   assign issue_last = w_ff == lastw_s_ff;
   assign emit_busy  = state_ff != EMIT_IDLE;
   assign rd_en      = issue;
   assign rd_addr    = {bank_s_ff, w_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EMIT_IDLE: begin
            if (done.valid) begin
               state_in = EMIT_SELECT;
            end
         end
         EMIT_SELECT: begin
            state_in = EMIT_ISSUE;
         end
         EMIT_ISSUE: begin
            if (issue && issue_last) begin
               state_in = EMIT_IDLE;
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= EMIT_IDLE;
         inflight_ff <= 1'b0;
         occ_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= issue;
         occ_ff      <= 2'(3'(occ_ff) + 3'(push) - 3'(pop));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == EMIT_IDLE && done.valid) begin
         cnt_s_ff   <= done_counts;
         qs_s_ff    <= done_qsums;
         len_s_ff   <= done_len;
         bank_s_ff  <= done.bank;
         ovf_s_ff   <= done.overflow;
         lastw_s_ff <= done_last_row;
      end
      if (state_ff == EMIT_SELECT) begin
         best_ff <= best_sel;
         bcnt_ff <= cnt_s_ff[best_sel];
         w_ff    <= '0;
      end else if (issue) begin
         w_ff <= w_ff + ROW_W'(1);
      end
      if (issue) begin
         inf_w_ff    <= w_ff;
         inf_last_ff <= issue_last;
      end
   end

   always_comb begin
      entry.best_offset    = OFFSET_OUT_W'(best_ff);
      entry.mismatch_count = bcnt_ff;
      entry.bitmap_word    = rd_data[best_ff*WORD_W +: WORD_W];
      entry.word_index     = WIDX_W'(inf_w_ff);
      entry.overflow       = ovf_s_ff;
      entry.last_word      = inf_last_ff;
   end

   assign slot = 1'(occ_ff - 2'(pop));

   always_ff @(posedge clock) begin
      if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push) begin
         q_ff[slot] <= entry;
      end
   end

   assign rsp_valid          = occ_ff != '0;
   assign rsp_best_offset    = q_ff[0].best_offset;
   assign rsp_mismatch_count = q_ff[0].mismatch_count;
   assign rsp_bitmap_word    = q_ff[0].bitmap_word;
   assign rsp_word_index     = q_ff[0].word_index;
   assign rsp_overflow       = q_ff[0].overflow;
   assign rsp_last_word      = q_ff[0].last_word;

endmodule
